[rtl/csut_pkg.sv]
// ----------------------------------------------------------------------------
// csut_pkg
// Shared types, widths and codes of the chi-square uniformity test block.
// ----------------------------------------------------------------------------
package csut_pkg;

  // Defaults of the top-level parameters.
  localparam int MAX_BINS_DEF    = 128;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed field widths.
  localparam int SPAN_W     = 17;
  localparam int NBINS_W    = 8;
  localparam int COUNT_W    = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int STAT_W     = 48;
  localparam int FRAC_W     = 16;

  // The squared-deviation sum of at most 255 bins of 20-bit counts fits 48 bits.
  localparam int ACC_W = 48;

  // Shared divider: the numerator is the sum scaled by the fraction bits.
  localparam int DIV_NUM_W = ACC_W + FRAC_W;
  localparam int DIV_DEN_W = COUNT_W;

  // Register reset values.
  localparam logic [SPAN_W-1:0]  SPAN_RST   = SPAN_W'(200);
  localparam logic [NBINS_W-1:0] NBINS_RST  = NBINS_W'(100);
  localparam logic [COUNT_W-1:0] SCOUNT_RST = COUNT_W'(5000);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANGE_SPAN   = 2'd0,
    CFG_NUM_BINS     = 2'd1,
    CFG_SAMPLE_COUNT = 2'd2
  } cfg_idx_t;

  // Divider operand selection.
  typedef enum logic {
    DIV_EXPECTED,
    DIV_STATISTIC
  } div_sel_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEARCH,
    ST_BIN,
    ST_WRITE,
    ST_EXP_START,
    ST_EXP_WAIT,
    ST_SWEEP,
    ST_DRAIN,
    ST_STAT_START,
    ST_STAT_WAIT,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     take;
    logic     search_step;
    logic     mem_rd;
    logic     mem_wr;
    logic     sweep_init;
    logic     sweep_step;
    logic     sum_en;
    logic     e_load;
    logic     div_start;
    div_sel_t div_sel;
    logic     out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic search_last;
    logic bin_ok;
    logic run_end;
    logic sweep_last;
    logic pipe_busy;
    logic div_busy;
    logic e_zero;
    logic out_free;
  } status_t;

endpackage

[rtl/csut_div.sv]
// ----------------------------------------------------------------------------
// csut_div
// Restoring divider, one quotient bit per cycle, shared by the expected-count
// and the statistic divisions.
// ----------------------------------------------------------------------------
module csut_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [csut_pkg::DIV_NUM_W-1:0] num,
  input  logic [csut_pkg::DIV_DEN_W-1:0] den,
  output logic                           busy,
  output logic [csut_pkg::DIV_NUM_W-1:0] quo
);
  import csut_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic [DIV_NUM_W-1:0] num_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 ge;

  // Shift the next numerator bit into the partial remainder and try a subtract.
  assign rem_sh = {rem_r, num_r[DIV_NUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, den_r});

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(DIV_NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Operands; the quotient bits replace the numerator from the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[DIV_NUM_W-2:0], ge};
      rem_r <= ge ? DIV_DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DIV_DEN_W-1:0];
    end
  end

  assign busy = busy_r;
  assign quo  = num_r;

endmodule

[rtl/csut_dp.sv]
// ----------------------------------------------------------------------------
// csut_dp
// Datapath: configuration registers, bin search, histogram memory, sum of
// squared deviations, shared divider and the result register.
// ----------------------------------------------------------------------------
module csut_dp #(
  parameter int MAX_BINS    = csut_pkg::MAX_BINS_DEF,
  parameter int SAMPLE_BITS = csut_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [csut_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csut_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [SAMPLE_BITS-1:0]          in_sample,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [csut_pkg::STAT_W-1:0]     out_statistic,
  output logic                            out_expected_zero_error,
  input  csut_pkg::cmd_t                  cmd,
  output csut_pkg::status_t               status
);
  import csut_pkg::*;

  localparam int IDXW = $clog2(MAX_BINS);
  localparam int TW   = IDXW + 1;
  localparam int NW   = SAMPLE_BITS + NBINS_W;
  localparam int PW   = TW + SPAN_W;
  localparam int CW   = (NW > PW) ? NW : PW;
  localparam int SQ_W = 2 * COUNT_W;

  // Configuration registers.
  logic [SPAN_W-1:0]  span_r;
  logic [NBINS_W-1:0] nbins_r;
  logic [COUNT_W-1:0] scount_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r   <= SPAN_RST;
      nbins_r  <= NBINS_RST;
      scount_r <= SCOUNT_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RANGE_SPAN:   span_r   <= cfg_data[SPAN_W-1:0];
        CFG_NUM_BINS:     nbins_r  <= cfg_data[NBINS_W-1:0];
        CFG_SAMPLE_COUNT: scount_r <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Bins in use: the register clamped to one up to MAX_BINS.
  logic [NBINS_W-1:0] nb;

  always_comb begin
    if (nbins_r == '0) begin
      nb = NBINS_W'(1);
    end else if (32'(nbins_r) > MAX_BINS) begin
      nb = NBINS_W'(MAX_BINS);
    end else begin
      nb = nbins_r;
    end
  end

  // Sample counter of the current run.
  logic [COUNT_W-1:0] seen_r;
  logic               run_end_r;
  logic [COUNT_W:0]   seen_inc;
  logic               run_end_nxt;

  assign seen_inc    = {1'b0, seen_r} + (COUNT_W + 1)'(1);
  assign run_end_nxt = (seen_inc >= {1'b0, scount_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r    <= '0;
      run_end_r <= 1'b0;
    end else if (cmd.take) begin
      seen_r    <= run_end_nxt ? '0 : seen_inc[COUNT_W-1:0];
      run_end_r <= run_end_nxt;
    end
  end

  // Bin search. The sample goes to the smallest j with (j+1)*span >= sample*B,
  // which is the largest t with t*span < sample*B, found one bit per cycle.
  logic [NW-1:0] prod_r;
  logic [TW-1:0] t_r;
  logic [TW-1:0] bit_r;
  logic [TW-1:0] cand;
  logic [PW-1:0] cand_prod;

  assign cand      = t_r | bit_r;
  assign cand_prod = PW'(cand) * PW'(span_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= '0;
    end else if (cmd.take) begin
      bit_r <= {1'b1, {(TW-1){1'b0}}};
    end else if (cmd.search_step) begin
      bit_r <= bit_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      prod_r <= NW'(in_sample) * NW'(nb);
      t_r    <= '0;
    end else if (cmd.search_step) begin
      if (CW'(cand_prod) < CW'(prod_r)) begin
        t_r <= cand;
      end
    end
  end

  // Histogram memory; its read and its write share one address.
  logic [COUNT_W-1:0] bin_mem_r [MAX_BINS];
  logic [COUNT_W-1:0] rd_data_r;
  logic [IDXW-1:0]    idx_r;
  logic [IDXW-1:0]    mem_addr;
  logic [COUNT_W-1:0] mem_wdata;
  logic               mem_re;
  logic               mem_we;
  logic [COUNT_W-1:0] cnt_inc;

  assign cnt_inc   = (rd_data_r == COUNT_MAX) ? rd_data_r : rd_data_r + COUNT_W'(1);
  assign mem_addr  = cmd.sweep_step ? idx_r : t_r[IDXW-1:0];
  assign mem_wdata = cmd.sweep_step ? '0 : cnt_inc;
  assign mem_re    = cmd.mem_rd | cmd.sweep_step;
  assign mem_we    = cmd.mem_wr | cmd.sweep_step;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bin_mem_r[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= bin_mem_r[mem_addr];
    end
  end

  // Sweep index over every entry; it reads for the sum and writes zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.sweep_init) begin
      idx_r <= '0;
    end else if (cmd.sweep_step) begin
      idx_r <= idx_r + IDXW'(1);
    end
  end

  // Sum pipeline: read, square of the deviation, accumulate.
  logic [COUNT_W-1:0] e_r;
  logic               rd_vld_r;
  logic               sq_vld_r;
  logic [SQ_W-1:0]    sq_r;
  logic [ACC_W-1:0]   acc_r;
  logic [COUNT_W-1:0] dev;

  assign dev = (rd_data_r >= e_r) ? rd_data_r - e_r : e_r - rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      sq_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.sweep_step & cmd.sum_en & (32'(idx_r) < 32'(nb));
      sq_vld_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      sq_r <= SQ_W'(dev) * SQ_W'(dev);
    end
    if (cmd.sweep_init) begin
      acc_r <= '0;
    end else if (sq_vld_r) begin
      acc_r <= acc_r + ACC_W'(sq_r);
    end
  end

  // Shared divider: expected count first, then the scaled statistic.
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_NUM_W-1:0] div_quo;
  logic                 div_busy;

  always_comb begin
    case (cmd.div_sel)
      DIV_EXPECTED: begin
        div_num = DIV_NUM_W'(scount_r);
        div_den = DIV_DEN_W'(nb);
      end
      DIV_STATISTIC: begin
        div_num = {acc_r, {FRAC_W{1'b0}}};
        div_den = e_r;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  csut_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.e_load) begin
      e_r <= div_quo[COUNT_W-1:0];
    end
  end

  // Result register, saturating the statistic at the field maximum.
  logic              out_valid_r;
  logic [STAT_W-1:0] stat_r;
  logic              err_r;
  logic [STAT_W-1:0] stat_sat;

  assign stat_sat = (div_quo[DIV_NUM_W-1:STAT_W] != '0) ? '1 : div_quo[STAT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      stat_r <= (e_r == '0) ? '0 : stat_sat;
      err_r  <= (e_r == '0);
    end
  end

  assign out_valid               = out_valid_r;
  assign out_statistic           = stat_r;
  assign out_expected_zero_error = err_r;

  // Status toward the controller.
  always_comb begin
    status.search_last = bit_r[0];
    status.bin_ok      = (32'(t_r) < 32'(nb));
    status.run_end     = run_end_r;
    status.sweep_last  = (idx_r == IDXW'(MAX_BINS - 1));
    status.pipe_busy   = rd_vld_r | sq_vld_r;
    status.div_busy    = div_busy;
    status.e_zero      = (e_r == '0);
    status.out_free    = ~out_valid_r | out_ready;
  end

endmodule

[rtl/csut_ctrl.sv]
// ----------------------------------------------------------------------------
// csut_ctrl
// Controller: sequences the sample update, the end-of-run reduction and the
// clearing sweeps of the histogram memory.
// ----------------------------------------------------------------------------
module csut_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  csut_pkg::status_t  status,
  output csut_pkg::cmd_t     cmd
);
  import csut_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register; reset starts with the clearing sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.div_sel = DIV_EXPECTED;
    in_ready    = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        cmd.sweep_step = 1'b1;
        if (status.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.search_step = 1'b1;
        if (status.search_last) begin
          state_nxt = ST_BIN;
        end
      end
      ST_BIN: begin
        // A sample above every bound skips the count update.
        if (status.bin_ok) begin
          cmd.mem_rd = 1'b1;
          state_nxt  = ST_WRITE;
        end else begin
          state_nxt = status.run_end ? ST_EXP_START : ST_IDLE;
        end
      end
      ST_WRITE: begin
        cmd.mem_wr = 1'b1;
        state_nxt  = status.run_end ? ST_EXP_START : ST_IDLE;
      end
      ST_EXP_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_EXPECTED;
        state_nxt     = ST_EXP_WAIT;
      end
      ST_EXP_WAIT: begin
        if (!status.div_busy) begin
          cmd.e_load     = 1'b1;
          cmd.sweep_init = 1'b1;
          state_nxt      = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        cmd.sum_en     = 1'b1;
        if (status.sweep_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = status.e_zero ? ST_EMIT : ST_STAT_START;
        end
      end
      ST_STAT_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_STATISTIC;
        state_nxt     = ST_STAT_WAIT;
      end
      ST_STAT_WAIT: begin
        if (!status.div_busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/chi_square_uniformity_test.sv]
// ----------------------------------------------------------------------------
// chi_square_uniformity_test
// Pearson chi-square test of a sample stream against a uniform distribution.
// ----------------------------------------------------------------------------
// Channel  Ports                                       Beat
// cfg      cfg_valid/ready, cfg_index, cfg_data        one register write
// in       in_valid/ready, in_sample                   one sample
// out      out_valid/ready, out_statistic,             one result per run
//          out_expected_zero_error
//
// A sample passes through the bin search, which resolves one
// index bit per cycle, then a read and a write of the histogram memory.
// The last sample of a run adds the divisions in the bit-serial divider and
// the sweep that sums and clears the histogram.
// After reset, a pass clearing every histogram entry runs before any sample.
// A waiting result does not block the next run's samples.
// ----------------------------------------------------------------------------
module chi_square_uniformity_test #(
  parameter int MAX_BINS    = csut_pkg::MAX_BINS_DEF,
  parameter int SAMPLE_BITS = csut_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [csut_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csut_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [SAMPLE_BITS-1:0]          in_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [csut_pkg::STAT_W-1:0]     out_statistic,
  output logic                            out_expected_zero_error
);
  import csut_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Register writes must arrive only while the block is idle (not enforced).
  assign cfg_ready = 1'b1;

  csut_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  csut_dp #(
    .MAX_BINS    (MAX_BINS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_valid               (cfg_valid),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data),
    .in_sample               (in_sample),
    .out_ready               (out_ready),
    .out_valid               (out_valid),
    .out_statistic           (out_statistic),
    .out_expected_zero_error (out_expected_zero_error),
    .cmd                     (cmd),
    .status                  (status)
  );

endmodule
